/* rtl/h264fua_pkg.sv */
`default_nettype none

package h264fua_pkg;

  // NAL unit types that get special handling.
  localparam logic [4:0] NAL_TYPE_SEI = 5'd6;
  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
  localparam logic [4:0] FUA_TYPE     = 5'd28;

  localparam int unsigned FRAG_W = 11;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned TS_W   = 32;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [FRAG_W-1:0] MIN_FRAGMENT       = 11'd1024;
  localparam logic [FRAG_W-1:0] RST_MAX_FRAGMENT   = 11'd1360;
  localparam logic [TS_W-1:0]   RST_TIMESTAMP_STEP = 32'd3000;

  typedef enum logic [1:0] {
    CFG_MAX_FRAGMENT,
    CFG_TIMESTAMP_STEP,
    CFG_START_SEQUENCE,
    CFG_START_TIMESTAMP
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]       nal_header;
    logic [LEN_W-1:0] nal_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       fu_ind;
    logic [7:0]       fu_hdr;
    logic             fragmented;
    logic [LEN_W-1:0] payload_offset;
    logic [LEN_W-1:0] payload_length;
    logic [SEQ_W-1:0] rtp_seq;
    logic [TS_W-1:0]  timestamp;
    logic             last;
  } out_item_t;

  // Microcode step addresses.
  typedef enum logic [1:0] {
    STEP_ACCEPT,
    STEP_FRAG,
    STEP_SINGLE
  } step_e;

  // Branch conditions tested by a control word.
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_SINGLE,
    COND_MORE
  } cond_e;

  typedef struct packed {
    logic  accept;  // take an input transaction, load the datapath
    logic  emit;    // write one descriptor to the output register
    logic  frag;    // descriptor is an FU-A fragment
    cond_e cond;
    step_e jmp;     // next step when the condition holds
    step_e nxt;     // next step otherwise
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic single;   // incoming unit goes out as a single packet
    logic more;     // bytes remain after the current fragment
  } seq_status_t;

  typedef struct packed {
    ctrl_t word;
    logic  fire;    // the current step completes this cycle
  } seq_out_t;

  // Control store. A whole unit is one accept step followed by one emit step
  // per packet.
  function automatic ctrl_t ucode_rom(step_e step);
    ctrl_t w;
    w = '{accept: 1'b0, emit: 1'b0, frag: 1'b0, cond: COND_NEVER,
          jmp: STEP_ACCEPT, nxt: STEP_ACCEPT};
    unique case (step)
      STEP_ACCEPT: begin
        w.accept = 1'b1;
        w.cond   = COND_SINGLE;
        w.jmp    = STEP_SINGLE;
        w.nxt    = STEP_FRAG;
      end
      STEP_FRAG: begin
        w.emit = 1'b1;
        w.frag = 1'b1;
        w.cond = COND_MORE;
        w.jmp  = STEP_FRAG;
        w.nxt  = STEP_ACCEPT;
      end
      STEP_SINGLE: begin
        w.emit = 1'b1;
        w.nxt  = STEP_ACCEPT;
      end
      default: begin
        w.nxt = STEP_ACCEPT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/h264fua_seq.sv */
`default_nettype none

// Step counter and control store of the packetizer.
module h264fua_seq (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire h264fua_pkg::seq_status_t  status_i,
  output h264fua_pkg::seq_out_t          ctrl_o
);

  h264fua_pkg::step_e pc_q, pc_d;
  h264fua_pkg::ctrl_t word;
  logic               taken;
  logic               fire;

  assign word = h264fua_pkg::ucode_rom(pc_q);

  always_comb begin
    unique case (word.cond)
      h264fua_pkg::COND_NEVER:  taken = 1'b0;
      h264fua_pkg::COND_SINGLE: taken = status_i.single;
      h264fua_pkg::COND_MORE:   taken = status_i.more;
      default:                  taken = 1'b0;
    endcase
  end

  // A step holds while it waits for an input or for room in the output.
  assign fire = !(word.accept && !status_i.in_valid) &&
                !(word.emit && !status_i.out_free);

  always_comb begin
    pc_d = pc_q;
    if (fire) begin
      pc_d = taken ? word.jmp : word.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= h264fua_pkg::STEP_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = '{word: word, fire: fire};

endmodule

`default_nettype wire

/* rtl/h264_rtp_fua_packetizer.sv */
`default_nettype none

// H.264 RTP packetizer for FU-A. Each input transaction names one NAL unit by
// its header byte and total length, and the block answers with one packet
// descriptor per RTP packet. SPS and PPS always go out as a single packet
// without a timestamp step; other units up to the fragment size go out as a
// single packet and step the timestamp unless they are SEI; longer units are
// cut into FU-A fragments of the fragment size over the bytes after the
// header byte, and only the first fragment steps the timestamp, unless the
// unit is SEI. Every packet increments the 16-bit sequence number first. A
// fragment size below 1024 is raised to 1024. Control comes from a three-step
// microcode program: one step accepts the unit and one step emits each
// descriptor, and an emit step waits while the output register is held by
// the consumer. The output register lets the last descriptor wait while the
// next transaction is accepted. Writing start_sequence or start_timestamp
// loads the matching counter; configuration is meant to be written while
// the block is idle.
module h264_rtp_fua_packetizer (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  wire h264fua_pkg::in_item_t              in_data_i,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output h264fua_pkg::out_item_t                  out_data_o,
  input  wire                                     cfg_we_i,
  input  wire h264fua_pkg::cfg_idx_e              cfg_idx_i,
  input  wire [h264fua_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned LW = h264fua_pkg::LEN_W;
  localparam int unsigned FW = h264fua_pkg::FRAG_W;

  // Configuration registers and packet counters.
  logic [FW-1:0]                   max_frag_q;
  logic [h264fua_pkg::TS_W-1:0]    ts_step_q;
  logic [h264fua_pkg::SEQ_W-1:0]   seq_q, seq_d;
  logic [h264fua_pkg::TS_W-1:0]    ts_q, ts_d;

  // Datapath registers of the unit in progress.
  logic [7:0]    hdr_q;
  logic [LW-1:0] off_q;
  logic [LW-1:0] left_q;
  logic          first_q;

  logic                    out_valid_q;
  h264fua_pkg::out_item_t  out_data_q, pkt;

  h264fua_pkg::seq_status_t status;
  h264fua_pkg::seq_out_t    ctrl;

  logic [FW-1:0] frag_eff;
  logic [LW-1:0] frag_ext;
  logic [4:0]    in_type;
  logic          in_single;
  logic [4:0]    cur_type;
  logic          cur_sei;
  logic          cur_pset;
  logic          more;
  logic          do_step;
  logic          accept_fire;
  logic          emit_fire;

  // The fragment size in effect never drops below the minimum.
  assign frag_eff = (max_frag_q < h264fua_pkg::MIN_FRAGMENT) ? h264fua_pkg::MIN_FRAGMENT
                                                             : max_frag_q;
  assign frag_ext = {{(LW-FW){1'b0}}, frag_eff};

  // The single-packet decision is made on the incoming fields during the
  // accept step, so the first descriptor follows in the emit step after it.
  assign in_type   = in_data_i.nal_header[4:0];
  assign in_single = (in_type == h264fua_pkg::NAL_TYPE_SPS) ||
                     (in_type == h264fua_pkg::NAL_TYPE_PPS) ||
                     (in_data_i.nal_length <= frag_ext);

  assign cur_type = hdr_q[4:0];
  assign cur_sei  = (cur_type == h264fua_pkg::NAL_TYPE_SEI);
  assign cur_pset = (cur_type == h264fua_pkg::NAL_TYPE_SPS) ||
                    (cur_type == h264fua_pkg::NAL_TYPE_PPS);

  // While fragmenting, left_q counts the body bytes not yet sent.
  assign more = (left_q > frag_ext);

  assign status = '{in_valid: in_valid_i,
                    out_free: !out_valid_q || out_ready_i,
                    single:   in_single,
                    more:     more};

  h264fua_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign in_ready_o  = ctrl.word.accept;
  assign accept_fire = ctrl.fire && ctrl.word.accept;
  assign emit_fire   = ctrl.fire && ctrl.word.emit;

  // Only the first packet of a NAL unit moves the timestamp: a single
  // packet unless it is a parameter set or SEI, or the first fragment of a
  // non-SEI unit.
  assign do_step = ctrl.word.frag ? (first_q && !cur_sei) : (!cur_sei && !cur_pset);

  assign seq_d = seq_q + 16'd1;
  assign ts_d  = ts_q + (do_step ? ts_step_q : '0);

  // Descriptor of the packet being emitted in this step.
  always_comb begin
    pkt.rtp_seq   = seq_d;
    pkt.timestamp = ts_d;
    if (ctrl.word.frag) begin
      pkt.fu_ind         = {1'b0, hdr_q[6:5], h264fua_pkg::FUA_TYPE};
      pkt.fu_hdr         = {first_q, !more, 1'b0, cur_type};
      pkt.fragmented     = 1'b1;
      pkt.payload_offset = off_q;
      pkt.payload_length = more ? frag_ext : left_q;
      pkt.last           = !more;
    end else begin
      pkt.fu_ind         = 8'd0;
      pkt.fu_hdr         = 8'd0;
      pkt.fragmented     = 1'b0;
      pkt.payload_offset = '0;
      pkt.payload_length = left_q;
      pkt.last           = 1'b1;
    end
  end

  // Configuration registers and the sequence and timestamp counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frag_q <= h264fua_pkg::RST_MAX_FRAGMENT;
      ts_step_q  <= h264fua_pkg::RST_TIMESTAMP_STEP;
      seq_q      <= '0;
      ts_q       <= '0;
    end else begin
      if (emit_fire) begin
        seq_q <= seq_d;
        ts_q  <= ts_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          h264fua_pkg::CFG_MAX_FRAGMENT:    max_frag_q <= cfg_data_i[FW-1:0];
          h264fua_pkg::CFG_TIMESTAMP_STEP:  ts_step_q  <= cfg_data_i;
          h264fua_pkg::CFG_START_SEQUENCE:  seq_q      <= cfg_data_i[h264fua_pkg::SEQ_W-1:0];
          h264fua_pkg::CFG_START_TIMESTAMP: ts_q       <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Unit datapath: a single packet keeps the whole length in left_q, a
  // fragmented unit starts after the header byte and walks forward by one
  // fragment per emitted descriptor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else if (accept_fire) begin
      first_q <= 1'b1;
    end else if (emit_fire) begin
      first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_fire) begin
      hdr_q  <= in_data_i.nal_header;
      off_q  <= 16'd1;
      left_q <= in_single ? in_data_i.nal_length : (in_data_i.nal_length - 16'd1);
    end else if (emit_fire && ctrl.word.frag) begin
      off_q  <= off_q + frag_ext;
      left_q <= left_q - frag_ext;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_data_q <= pkt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A descriptor is only written when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> (!out_valid_q || out_ready_i))
    else $error("descriptor written over a pending transaction");

  // Every emitted packet advances the sequence number by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && !cfg_we_i) |=> (seq_q == $past(seq_q) + 16'd1))
    else $error("sequence number did not advance by one");

  // The final fragment of a unit returns the program to the accept step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && ctrl.word.frag && !more) |=> in_ready_o)
    else $error("sequencer did not return after the last fragment");

  // A fragment descriptor always carries the FU-A type in its indicator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fragmented) |->
      (out_data_o.fu_ind[4:0] == h264fua_pkg::FUA_TYPE))
    else $error("fragment without FU-A indicator type");

endmodule

`default_nettype wire
